// ===== rtl/sfd_pkg.sv =====
// Shared constants and types for the serial frame deframer.
package sfd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned ActW  = 2;

	localparam logic [ByteW-1:0] HdrFirst  = 8'hA5;
	localparam logic [ByteW-1:0] HdrSecond = 8'h5A;
	localparam logic [ByteW-1:0] Trailer   = 8'hAA;

	localparam logic [ByteW-1:0] MinLengthReset = 8'd3;
	localparam logic [ByteW-1:0] MaxLengthReset = 8'd49;

	typedef enum logic [ActW-1:0] {
		ACT_IGNORE   = 2'd0,
		ACT_PUSH     = 2'd1,
		ACT_DISCARD  = 2'd2,
		ACT_COMPLETE = 2'd3
	} action_t;

	typedef enum logic {
		CMD_BYTE    = 1'b0,
		CMD_RELEASE = 1'b1
	} command_t;

	typedef enum logic {
		REG_MIN_LENGTH = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_index_t;

endpackage

// ===== rtl/serial_frame_deframer.sv =====
// Top level of the serial frame deframer: byte classifier with a frame gate.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata = rx_byte, s_tuser = command
//   m_       out  m_tvalid/m_tready  m_tdata = type byte, m_tuser = action
//   cfg_     in   cfg_we             cfg_index, cfg_data (min/max length)
//
// One byte per cycle unless the output stalls: each transfer is classified in the
// cycle it arrives and its result lands in the output register on the same edge.
// The output register is refilled while it is being drained, so a new transfer
// is taken whenever the output is empty or taken in the same cycle.
// Reset clears the parser to wait for the first header with the gate open and
// the length bounds at 3..49.
module serial_frame_deframer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [sfd_pkg::ByteW-1:0] s_tdata,   // [7:0] rx_byte
	input  logic                      s_tuser,   // [0] command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [sfd_pkg::ByteW-1:0] m_tdata,   // [7:0] type byte of the completed frame
	output logic [sfd_pkg::ActW-1:0]  m_tuser,   // [1:0] action
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [sfd_pkg::ByteW-1:0] cfg_data
);

	typedef enum logic [2:0] {
		PH_HDR1    = 3'd0,
		PH_HDR2    = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_TRAILER = 3'd5
	} phase_t;

	logic [sfd_pkg::ByteW-1:0] min_length_q, max_length_q;
	phase_t                    phase_q, phase_d;
	logic [sfd_pkg::ByteW-1:0] length_q, length_d;
	logic [sfd_pkg::ByteW-1:0] count_q, count_d;
	logic [sfd_pkg::ByteW-1:0] type_q, type_d;
	logic                      gate_q, gate_d;
	sfd_pkg::action_t          act_d, act_q;
	logic [sfd_pkg::ByteW-1:0] ftype_d, ftype_q;
	logic                      out_valid_q;
	logic                      accept;
	logic [sfd_pkg::ByteW:0]   count_inc;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign count_inc = {1'b0, count_q} + {{sfd_pkg::ByteW{1'b0}}, 1'b1};

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		count_d  = count_q;
		type_d   = type_q;
		gate_d   = gate_q;
		act_d    = sfd_pkg::ACT_IGNORE;
		ftype_d  = '0;
		if (s_tuser == sfd_pkg::CMD_RELEASE) begin
			gate_d = 1'b1;
		end else if (gate_q) begin
			unique case (phase_q)
				PH_HDR1: begin
					if (s_tdata == sfd_pkg::HdrFirst) begin
						act_d   = sfd_pkg::ACT_PUSH;
						phase_d = PH_HDR2;
					end else begin
						act_d = sfd_pkg::ACT_DISCARD;
					end
				end
				PH_HDR2: begin
					if (s_tdata == sfd_pkg::HdrSecond) begin
						act_d   = sfd_pkg::ACT_PUSH;
						phase_d = PH_LENGTH;
						count_d = '0;
					end else begin
						act_d   = sfd_pkg::ACT_DISCARD;
						phase_d = PH_HDR1;
					end
				end
				PH_LENGTH: begin
					length_d = s_tdata;
					if (s_tdata >= min_length_q && s_tdata <= max_length_q) begin
						act_d   = sfd_pkg::ACT_PUSH;
						count_d = count_inc[sfd_pkg::ByteW-1:0];
						phase_d = PH_TYPE;
					end else begin
						act_d   = sfd_pkg::ACT_DISCARD;
						phase_d = PH_HDR1;
					end
				end
				PH_TYPE: begin
					act_d   = sfd_pkg::ACT_PUSH;
					type_d  = s_tdata;
					count_d = count_inc[sfd_pkg::ByteW-1:0];
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					// The count runs from the length byte, so the trailer follows
					// once it reaches the length value.
					if (count_q < length_q) begin
						if (count_inc == {1'b0, length_q}) begin
							phase_d = PH_TRAILER;
						end
						act_d   = sfd_pkg::ACT_PUSH;
						count_d = count_inc[sfd_pkg::ByteW-1:0];
					end else begin
						act_d   = sfd_pkg::ACT_DISCARD;
						phase_d = PH_HDR1;
					end
				end
				PH_TRAILER: begin
					if (s_tdata == sfd_pkg::Trailer) begin
						act_d   = sfd_pkg::ACT_COMPLETE;
						ftype_d = type_q;
						gate_d  = 1'b0;
					end else begin
						act_d = sfd_pkg::ACT_DISCARD;
					end
					phase_d = PH_HDR1;
				end
				default: begin
					act_d   = sfd_pkg::ACT_DISCARD;
					phase_d = PH_HDR1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= sfd_pkg::MinLengthReset;
			max_length_q <= sfd_pkg::MaxLengthReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfd_pkg::REG_MIN_LENGTH: min_length_q <= cfg_data;
				sfd_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR1;
			length_q    <= '0;
			count_q     <= '0;
			type_q      <= '0;
			gate_q      <= 1'b1;
			out_valid_q <= 1'b0;
			act_q       <= sfd_pkg::ACT_IGNORE;
			ftype_q     <= '0;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				length_q <= length_d;
				count_q  <= count_d;
				type_q   <= type_d;
				gate_q   <= gate_d;
				act_q    <= act_d;
				ftype_q  <= ftype_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ftype_q;
	assign m_tuser  = act_q;

endmodule
